>>> rtl/assert_macros.svh
// Assertion helpers for the checker module spma_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define SPMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define SPMA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/spma_pkg.sv
`default_nettype none

package spma_pkg;

  localparam logic [1:0] REQ_LOAD_A  = 2'd0;
  localparam logic [1:0] REQ_LOAD_B  = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  typedef struct packed {
    logic [1:0]          req_type;
    logic signed [15:0]  term_coeff;
    logic [15:0]         term_expo;
  } in_word_t;

  typedef struct packed {
    logic signed [16:0]  sum_coeff;
    logic [15:0]         sum_expo;
    logic                term_valid;
    logic                last_term;
    logic                overflow;
  } out_word_t;

  // One stored term: coefficient in the upper half, exponent in the lower.
  localparam int TermW = 32;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic a_has;
    logic b_has;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/spma_ram.sv
`default_nettype none

module spma_ram #(
  parameter int Width = 32,
  parameter int Depth = 32,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/spma_ctrl.sv
`default_nettype none

module spma_ctrl import spma_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_req_i,
  output logic       in_stall_o,
  input  dp_sts_t    sts_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [0:0] StIdle  = 1'b0;
  localparam logic [0:0] StMerge = 1'b1;

  logic [0:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != StIdle);
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          case (in_req_i)
            REQ_LOAD_A: cmd_o.load_a = 1'b1;
            REQ_LOAD_B: cmd_o.load_b = 1'b1;
            REQ_COMPUTE: begin
              cmd_o.start = 1'b1;
              state_d     = StMerge;
            end
            default: ;
          endcase
        end
      end
      StMerge: begin
        // advance only when the output register can take a word
        if (sts_i.out_free) begin
          if (sts_i.a_has || sts_i.b_has) begin
            cmd_o.step = 1'b1;
          end else begin
            cmd_o.finish = 1'b1;
            state_d      = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/spma_dp.sv
`default_nettype none

module spma_dp import spma_pkg::*; #(
  parameter int TERMS_PER_LIST = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_word_i,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output out_word_t out_word_o
);

  localparam int CntW = $clog2(TERMS_PER_LIST + 1);
  localparam int IdxW = (TERMS_PER_LIST > 1) ? $clog2(TERMS_PER_LIST) : 1;
  localparam logic [CntW-1:0] CntMax = CntW'(TERMS_PER_LIST);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  logic [CntW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CntW-1:0] i_q, i_d, j_q, j_d;
  logic            ovf_q, ovf_d;
  logic            pend_v_q, pend_v_d, out_v_q, out_v_d;
  out_word_t       pend_q, pend_d, out_q, out_d, cand;

  logic [TermW-1:0]   rd_a, rd_b, wr_term;
  logic signed [15:0] a_coeff, b_coeff;
  logic [15:0]        a_expo, b_expo;
  logic signed [16:0] a_ext, b_ext, sum;
  logic               a_full, b_full, a_has, b_has;
  logic               same, take_a, take_b, out_free;

  assign a_full  = (cnt_a_q == CntMax);
  assign b_full  = (cnt_b_q == CntMax);
  assign wr_term = {in_word_i.term_coeff, in_word_i.term_expo};

  // reads are addressed with the next index, so the heads line up with i_q and j_q
  spma_ram #(.Width(TermW), .Depth(TERMS_PER_LIST)) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load_a && !a_full),
    .waddr_i(cnt_a_q[IdxW-1:0]),
    .wdata_i(wr_term),
    .raddr_i(i_d[IdxW-1:0]),
    .rdata_o(rd_a)
  );

  spma_ram #(.Width(TermW), .Depth(TERMS_PER_LIST)) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load_b && !b_full),
    .waddr_i(cnt_b_q[IdxW-1:0]),
    .wdata_i(wr_term),
    .raddr_i(j_d[IdxW-1:0]),
    .rdata_o(rd_b)
  );

  assign a_coeff = signed'(rd_a[31:16]);
  assign a_expo  = rd_a[15:0];
  assign b_coeff = signed'(rd_b[31:16]);
  assign b_expo  = rd_b[15:0];
  assign a_ext   = 17'(a_coeff);
  assign b_ext   = 17'(b_coeff);
  assign sum     = a_ext + b_ext;

  assign a_has    = (i_q < cnt_a_q);
  assign b_has    = (j_q < cnt_b_q);
  assign same     = a_has && b_has && (a_expo == b_expo);
  assign take_a   = !same && (!b_has || (a_has && (a_expo > b_expo)));
  assign take_b   = !same && !take_a;
  assign out_free = !out_v_q || !out_stall_i;

  always_comb begin
    cand            = '0;
    cand.term_valid = 1'b1;
    if (same) begin
      cand.sum_coeff = sum;
      cand.sum_expo  = a_expo;
    end else if (take_a) begin
      cand.sum_coeff = a_ext;
      cand.sum_expo  = a_expo;
    end else begin
      cand.sum_coeff = b_ext;
      cand.sum_expo  = b_expo;
    end
  end

  always_comb begin
    cnt_a_d  = cnt_a_q;
    cnt_b_d  = cnt_b_q;
    ovf_d    = ovf_q;
    i_d      = i_q;
    j_d      = j_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    out_d    = out_q;
    out_v_d  = out_v_q && out_stall_i;

    if (cmd_i.load_a) begin
      if (a_full) begin
        ovf_d = 1'b1;
      end else begin
        cnt_a_d = cnt_a_q + CntOne;
      end
    end
    if (cmd_i.load_b) begin
      if (b_full) begin
        ovf_d = 1'b1;
      end else begin
        cnt_b_d = cnt_b_q + CntOne;
      end
    end

    if (cmd_i.start) begin
      i_d      = '0;
      j_d      = '0;
      pend_v_d = 1'b0;
    end

    if (cmd_i.step) begin
      if (same || take_a) begin
        i_d = i_q + CntOne;
      end
      if (same || take_b) begin
        j_d = j_q + CntOne;
      end
      // drop a matched pair that cancels; otherwise hold the new term and
      // release the one before it, which is now known not to be last
      if (!same || (sum != '0)) begin
        pend_d   = cand;
        pend_v_d = 1'b1;
        if (pend_v_q) begin
          out_d          = pend_q;
          out_d.overflow = ovf_q;
          out_v_d        = 1'b1;
        end
      end
    end

    if (cmd_i.finish) begin
      if (pend_v_q) begin
        out_d = pend_q;
      end else begin
        out_d = '0;
      end
      out_d.last_term = 1'b1;
      out_d.overflow  = ovf_q;
      out_v_d         = 1'b1;
      pend_v_d        = 1'b0;
      cnt_a_d         = '0;
      cnt_b_d         = '0;
      ovf_d           = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q  <= '0;
      cnt_b_q  <= '0;
      ovf_q    <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      cnt_a_q  <= cnt_a_d;
      cnt_b_q  <= cnt_b_d;
      ovf_q    <= ovf_d;
      i_q      <= i_d;
      j_q      <= j_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign sts_o.a_has    = a_has;
  assign sts_o.b_has    = b_has;
  assign sts_o.out_free = out_free;
  assign out_valid_o    = out_v_q;
  assign out_word_o     = out_q;

endmodule

`default_nettype wire

>>> rtl/sparse_poly_merge_add.sv
// Sparse polynomial adder. Load words append one term to list A or list B
// and are taken one per cycle while no compute runs; a load into a full list
// drops the term and sets the sticky overflow flag. A compute word merges both
// lists in descending exponent order, one merge step per cycle while the
// output is not stalled: each step consumes the head of A, of B, or of both
// (matched exponents, summed, dropped if the sum is zero), limited by the
// single read port of each list RAM. A closing step then sends the last
// word; the input stalls for the whole run. The last result word carries
// last_term; an empty sum yields one word with term_valid low. Both lists
// and the overflow flag clear at the end of the run.
`default_nettype none

module sparse_poly_merge_add import spma_pkg::*; #(
  parameter int TERMS_PER_LIST = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  spma_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_req_i  (in_word_i.req_type),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  spma_dp #(.TERMS_PER_LIST(TERMS_PER_LIST)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_word_o (out_word_o)
  );

endmodule

`default_nettype wire

>>> rtl/spma_chk.sv
`default_nettype none
`include "assert_macros.svh"

module spma_chk import spma_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  `SPMA_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o), "stalled result word changed")
  `SPMA_ASSERT(a_empty_last, out_valid_o && !out_word_o.term_valid |-> out_word_o.last_term && (out_word_o.sum_coeff == '0) && (out_word_o.sum_expo == '0), "empty-sum word malformed")
  `SPMA_ASSERT(a_load_no_stall, in_valid_i && !in_stall_o && ((in_word_i.req_type == REQ_LOAD_A) || (in_word_i.req_type == REQ_LOAD_B)) |=> !in_stall_o, "input stalled after a load")
  `SPMA_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o && !in_stall_o, "ports not quiet in reset")

endmodule

bind sparse_poly_merge_add spma_chk u_chk (.*);

`default_nettype wire

>>> verif/sparse_poly_merge_add_check.sv
`default_nettype none

module sparse_poly_merge_add_check import spma_pkg::*; #(
  parameter int TERMS_PER_LIST = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_word_t  in_word_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_word_t out_word_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        result_count_o
);

  logic [15:0] a_coeff [TERMS_PER_LIST];
  logic [15:0] a_expo  [TERMS_PER_LIST];
  logic [15:0] b_coeff [TERMS_PER_LIST];
  logic [15:0] b_expo  [TERMS_PER_LIST];
  int          a_len;
  int          b_len;
  logic        overflow_seen;
  out_word_t   sum_terms_q[$];
  int          fails;
  int          results;

  function automatic out_word_t term_word(logic [16:0] coeff, logic [15:0] expo,
                                          logic valid);
    out_word_t w;
    w.sum_coeff  = coeff;
    w.sum_expo   = expo;
    w.term_valid = valid;
    w.last_term  = 1'b0;
    w.overflow   = overflow_seen;
    return w;
  endfunction

  // Drop the term and flag overflow once the target list is full.
  function automatic void load_term(logic to_b, logic [15:0] coeff, logic [15:0] expo);
    if (!to_b && a_len < TERMS_PER_LIST) begin
      a_coeff[a_len] = coeff;
      a_expo[a_len]  = expo;
      a_len++;
    end else if (to_b && b_len < TERMS_PER_LIST) begin
      b_coeff[b_len] = coeff;
      b_expo[b_len]  = expo;
      b_len++;
    end else begin
      overflow_seen = 1'b1;
    end
  endfunction

  // Two-way merge on the stored lists, taken in the order they were loaded.
  function automatic void merge_lists();
    out_word_t   run_q[$];
    out_word_t   tail;
    logic [16:0] sum;
    int          i;
    int          j;
    i = 0;
    j = 0;
    while (i < a_len || j < b_len) begin
      if (i < a_len && j < b_len && a_expo[i] == b_expo[j]) begin
        sum = {a_coeff[i][15], a_coeff[i]} + {b_coeff[j][15], b_coeff[j]};
        if (sum != '0) run_q.push_back(term_word(sum, a_expo[i], 1'b1));
        i++;
        j++;
      end else if (j >= b_len || (i < a_len && a_expo[i] > b_expo[j])) begin
        run_q.push_back(term_word({a_coeff[i][15], a_coeff[i]}, a_expo[i], 1'b1));
        i++;
      end else begin
        run_q.push_back(term_word({b_coeff[j][15], b_coeff[j]}, b_expo[j], 1'b1));
        j++;
      end
    end
    // An empty sum still closes the run with one invalid word.
    if (run_q.size() == 0) run_q.push_back(term_word('0, '0, 1'b0));
    tail = run_q.pop_back();
    tail.last_term = 1'b1;
    run_q.push_back(tail);
    foreach (run_q[k]) sum_terms_q.push_back(run_q[k]);
    a_len = 0;
    b_len = 0;
    overflow_seen = 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      a_len = 0;
      b_len = 0;
      overflow_seen = 1'b0;
      sum_terms_q.delete();
      fails = 0;
      results = 0;
    end else begin
      // Check first: a word taken at this edge cannot answer an input of the same edge.
      if (out_valid_i && !out_stall_i) begin
        results++;
        if (sum_terms_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected sum word: coeff %0d expo %0d valid %b last %b ovf %b",
                   $time, out_word_i.sum_coeff, out_word_i.sum_expo,
                   out_word_i.term_valid, out_word_i.last_term, out_word_i.overflow);
        end else begin
          want = sum_terms_q.pop_front();
          if (out_word_i.sum_coeff !== want.sum_coeff ||
              out_word_i.sum_expo !== want.sum_expo ||
              out_word_i.term_valid !== want.term_valid ||
              out_word_i.last_term !== want.last_term ||
              out_word_i.overflow !== want.overflow) begin
            fails++;
            $display("%0t: sum word mismatch: expected coeff %0d expo %0d valid %b last %b ovf %b",
                     $time, want.sum_coeff, want.sum_expo, want.term_valid,
                     want.last_term, want.overflow);
            $display("%0t:                     actual coeff %0d expo %0d valid %b last %b ovf %b",
                     $time, out_word_i.sum_coeff, out_word_i.sum_expo,
                     out_word_i.term_valid, out_word_i.last_term, out_word_i.overflow);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (in_word_i.req_type)
          REQ_LOAD_A:  load_term(1'b0, in_word_i.term_coeff, in_word_i.term_expo);
          REQ_LOAD_B:  load_term(1'b1, in_word_i.term_coeff, in_word_i.term_expo);
          REQ_COMPUTE: merge_lists();
          default: ;
        endcase
      end
    end
    fail_count_o   <= fails;
    pending_o      <= sum_terms_q.size();
    result_count_o <= results;
  end

endmodule

`default_nettype wire

>>> verif/sparse_poly_merge_add_test.sv
`default_nettype none

module sparse_poly_merge_add_test;
  import spma_pkg::*;

  localparam int         TermsPerList = 32;
  localparam int         ItemsTarget  = 480;
  localparam logic [1:0] ReqUnused    = 2'd3;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  int fail_count;
  int pending_terms;
  int result_count;
  int send_idle_pct = 32;
  int recv_idle_pct = 32;
  int hold_cycles   = 0;
  int words_sent    = 0;
  int sums_sent     = 0;

  sparse_poly_merge_add #(
    .TERMS_PER_LIST(TermsPerList)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  sparse_poly_merge_add_check #(
    .TERMS_PER_LIST(TermsPerList)
  ) i_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_word_i     (in_word_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_word_i    (out_word_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending_terms),
    .result_count_o(result_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result side: random stalls, or a counted hold-off when one is requested.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("sparse_poly_merge_add_test NOT OK");
    $finish;
  end

  function automatic logic [15:0] rand_coeff();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_word(input logic [1:0] req, input logic [15:0] coeff,
                           input logic [15:0] expo);
    in_word_t w;
    w.req_type   = req;
    w.term_coeff = coeff;
    w.term_expo  = expo;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (req == REQ_LOAD_A || req == REQ_LOAD_B || req == REQ_COMPUTE) words_sent++;
    if (req == REQ_COMPUTE) sums_sent++;
  endtask

  // Stop offering and wait for every predicted sum word.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_terms != 0) @(posedge clk_i);
  endtask

  // Load na terms into A and nb into B, interleaved, then compute.
  task automatic run_sum(input int na, input int nb, input bit sorted);
    logic [15:0] a_c[$];
    logic [15:0] a_e[$];
    logic [15:0] b_c[$];
    logic [15:0] b_e[$];
    logic [15:0] expo_now;
    logic [15:0] coeff;
    int          pick;
    int          step;
    expo_now = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom());
    while (a_c.size() < na || b_c.size() < nb) begin
      coeff = rand_coeff();
      pick  = $urandom_range(2);
      if (a_c.size() >= na) pick = 1;
      else if (b_c.size() >= nb) pick = 0;
      if (!sorted) expo_now = $urandom_range(1) ? 16'($urandom_range(15)) : 16'($urandom());
      if (pick != 1) begin
        a_c.push_back(coeff);
        a_e.push_back(expo_now);
      end
      if (pick != 0) begin
        // Matched pairs sometimes cancel to exercise the zero-sum drop.
        if (pick == 2) coeff = ($urandom_range(3) == 0) ? -coeff : rand_coeff();
        b_c.push_back(coeff);
        b_e.push_back(expo_now);
      end
      if (sorted) begin
        step = $urandom_range(1, 1 + 65535 / (na + nb + 1));
        if (expo_now < step) expo_now = '0;
        else expo_now -= 16'(step);
      end
    end
    while (a_c.size() != 0 || b_c.size() != 0) begin
      if ($urandom_range(19) == 0) send_word(ReqUnused, 16'($urandom()), 16'($urandom()));
      if (b_c.size() == 0 || (a_c.size() != 0 && $urandom_range(1)))
        send_word(REQ_LOAD_A, a_c.pop_front(), a_e.pop_front());
      else
        send_word(REQ_LOAD_B, b_c.pop_front(), b_e.pop_front());
    end
    send_word(REQ_COMPUTE, 16'($urandom()), 16'($urandom()));
  endtask

  // Mostly short lists; a few full or overflowing ones.
  task automatic random_sum();
    int r;
    r = $urandom_range(99);
    if (r < 70)
      run_sum($urandom_range(6), $urandom_range(6), $urandom_range(99) < 85);
    else if (r < 90)
      run_sum($urandom_range(16), $urandom_range(16), $urandom_range(99) < 85);
    else
      run_sum($urandom_range(28, 34), $urandom_range(28, 34), $urandom_range(99) < 85);
  endtask

  initial begin
    in_valid_i = 1'b0;
    in_word_i  = '0;
    rst_ni    <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty lists give a single invalid word
    send_word(REQ_COMPUTE, 16'h1234, 16'hABCD);
    // extreme coefficients and exponents, a stored zero term, a cancelling pair
    send_word(REQ_LOAD_A, 16'h7FFF, 16'hFFFF);
    send_word(REQ_LOAD_B, 16'h7FFF, 16'hFFFF);
    send_word(REQ_LOAD_A, 16'h0000, 16'd100);
    send_word(REQ_LOAD_A, 16'hFFFB, 16'd7);
    send_word(REQ_LOAD_B, 16'h0005, 16'd7);
    send_word(REQ_LOAD_A, 16'h8000, 16'h0000);
    send_word(REQ_LOAD_B, 16'h8000, 16'h0000);
    send_word(REQ_COMPUTE, 16'hFFFF, 16'hFFFF);
    // unused request code is ignored; list B alone is copied out
    send_word(ReqUnused, 16'hFFFF, 16'hFFFF);
    send_word(REQ_LOAD_B, 16'h0001, 16'h8000);
    send_word(REQ_COMPUTE, 16'h0000, 16'h0000);
    // unsorted and repeated exponents
    send_word(REQ_LOAD_A, 16'd1, 16'd5);
    send_word(REQ_LOAD_A, 16'd2, 16'd9);
    send_word(REQ_LOAD_B, 16'd3, 16'd5);
    send_word(REQ_LOAD_B, 16'd4, 16'd5);
    send_word(REQ_COMPUTE, 16'h5555, 16'hAAAA);
    // every pair cancels: empty sum
    send_word(REQ_LOAD_A, 16'd7, 16'd3);
    send_word(REQ_LOAD_B, 16'hFFF9, 16'd3);
    send_word(REQ_COMPUTE, 16'hAAAA, 16'h5555);

    while (words_sent < 160) random_sum();

    // run flat out on both sides for a stretch
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (words_sent < 260) random_sum();
    send_idle_pct = 32;
    recv_idle_pct = 32;

    // hold the result side so the merge backs up into the input
    hold_cycles = 300;
    run_sum(20, 20, 1'b1);
    run_sum(3, 3, 1'b1);
    wait_drained();

    while (words_sent < ItemsTarget) random_sum();

    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("Ran %0d load/sum words (%0d sums) incl. overflowing lists and empty sums,",
             words_sent, sums_sent);
    $display("with random stalls on both sides; %0d result words checked.", result_count);
    if (fail_count == 0) begin
      $display("sparse_poly_merge_add_test OK");
    end else begin
      $display("sparse_poly_merge_add_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/spma_pkg.sv
rtl/spma_ram.sv
rtl/spma_ctrl.sv
rtl/spma_dp.sv
rtl/sparse_poly_merge_add.sv
rtl/spma_chk.sv
verif/sparse_poly_merge_add_check.sv
verif/sparse_poly_merge_add_test.sv
